// ===== rtl/core/sctc_pkg.sv =====
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared types, constants and tables for the wait-state and timer chain.
// ----------------------------------------------------------------------------
package sctc_pkg;

	// Prescale lengths: timers 0 and 1 run slow, timer 2 runs fast
	localparam int unsigned SLOW_PRESCALE = 128;
	localparam int unsigned FAST_PRESCALE = 16;

	localparam int unsigned PRE_W   = 9;
	localparam int unsigned TICK_W  = 5;
	localparam int unsigned CLK_W   = 8;
	localparam int unsigned CMP_W   = 8;
	localparam int unsigned OCNT_W  = 4;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 8;
	localparam int unsigned NUM_TIMERS = 3;

	typedef logic [1:0] speed_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXT_SPEED  = 4'd0,
		REG_INT_SPEED  = 4'd1,
		REG_BOOT_ROM   = 4'd2,
		REG_RUNNING    = 4'd3,
		REG_EN_MASK    = 4'd4,
		REG_TARGET0    = 4'd5,
		REG_TARGET1    = 4'd6,
		REG_TARGET2    = 4'd7
	} cfg_reg_t;

	// Master clocks per access: 12 * {2,4,10,20}
	localparam logic [CLK_W-1:0] COST_TABLE [4] = '{8'd24, 8'd48, 8'd120, 8'd240};
	// Prescaler ticks per access
	localparam logic [TICK_W-1:0] TICK_TABLE [4] = '{5'd2, 5'd4, 5'd8, 5'd16};

	// Address decode constants
	localparam logic [ADDR_W-1:0] IO_PAGE_MASK = 16'hFFF0;
	localparam logic [ADDR_W-1:0] IO_PAGE_BASE = 16'h00F0;
	localparam logic [ADDR_W-1:0] BOOT_ROM_BASE = 16'hFFC0;

	// Per-access control broadcast to every timer
	typedef struct packed {
		logic              adv;
		logic [TICK_W-1:0] ticks;
		logic              running;
	} timer_ctrl_t;

endpackage

// ===== rtl/core/sctc_wait_sel.sv =====
// ----------------------------------------------------------------------------
// sctc_wait_sel
// Address decode to wait-state index, cost and tick count.
// ----------------------------------------------------------------------------
module sctc_wait_sel (
	input  logic [sctc_pkg::ADDR_W-1:0] addr,
	input  sctc_pkg::speed_t            ext_speed,
	input  sctc_pkg::speed_t            int_speed,
	input  logic                        boot_rom_enabled,
	output logic [sctc_pkg::CLK_W-1:0]  cost,
	output logic [sctc_pkg::TICK_W-1:0] ticks
);
	import sctc_pkg::*;

	logic   io_hit;
	logic   rom_hit;
	speed_t sel;

	// IO page and mapped boot ROM run at internal speed
	assign io_hit  = (addr & IO_PAGE_MASK) == IO_PAGE_BASE;
	assign rom_hit = boot_rom_enabled && (addr >= BOOT_ROM_BASE);
	assign sel     = (io_hit || rom_hit) ? int_speed : ext_speed;

	assign cost  = COST_TABLE[sel];
	assign ticks = TICK_TABLE[sel];

endmodule

// ===== rtl/core/sctc_timer.sv =====
// ----------------------------------------------------------------------------
// sctc_timer
// One timer: prescaler, toggle stage, gated falling-edge detect,
// compare stage and 4-bit output counter.
// ----------------------------------------------------------------------------
module sctc_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sctc_pkg::timer_ctrl_t       ctrl,
	input  logic                        fast,
	input  logic                        enable,
	input  logic [sctc_pkg::CMP_W-1:0]  target,
	output logic [sctc_pkg::OCNT_W-1:0] count
);
	import sctc_pkg::*;

	logic [PRE_W-1:0]  pre_q;
	logic              toggle_q;
	logic              last_q;
	logic [CMP_W-1:0]  cmp_q;
	logic [OCNT_W-1:0] ocnt_q;

	logic [PRE_W-1:0]  len;
	logic [PRE_W-1:0]  pre_sum;
	logic              fire;
	logic              toggle_n;
	logic              line;
	logic              fall;
	logic              inc;
	logic [CMP_W-1:0]  cmp_inc;
	logic              match;

	// Prescaler: add ticks, subtract length once on overflow
	assign len     = fast ? PRE_W'(FAST_PRESCALE) : PRE_W'(SLOW_PRESCALE);
	assign pre_sum = pre_q + PRE_W'(ctrl.ticks);
	assign fire    = pre_sum >= len;

	// Toggle and gated edge line
	assign toggle_n = toggle_q ^ fire;
	assign line     = ctrl.running & toggle_n;
	assign fall     = fire & last_q & ~line;

	// Compare stage, target zero wraps through 256
	assign inc     = fall & enable;
	assign cmp_inc = cmp_q + 1'b1;
	assign match   = cmp_inc == target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q    <= '0;
			toggle_q <= 1'b0;
			last_q   <= 1'b0;
			cmp_q    <= '0;
			ocnt_q   <= '0;
		end else if (ctrl.adv) begin
			pre_q <= fire ? (pre_sum - len) : pre_sum;
			if (fire) begin
				toggle_q <= toggle_n;
				last_q   <= line;
			end
			if (inc) begin
				cmp_q <= match ? '0 : cmp_inc;
				if (match) begin
					ocnt_q <= ocnt_q + 1'b1;
				end
			end
		end
	end

	assign count = ocnt_q;

endmodule

// ===== rtl/core/sound_cpu_wait_and_timer_chain.sv =====
// ----------------------------------------------------------------------------
// sound_cpu_wait_and_timer_chain
// Bus access wait-state cost and three chained sound timers.
// ----------------------------------------------------------------------------
// Pipeline: a request is captured in the input register, then moves into the
//   timer state and result register when the result slot is free or draining.
// Throughput: one request per cycle unless stalled; single add/compare update.
// Reset: asynchronous, clears pipeline valids, timer state and config
//   (boot ROM mapped and timers running after reset).
module sound_cpu_wait_and_timer_chain (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sctc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sctc_pkg::CFG_DAT_W-1:0] cfg_data,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sctc_pkg::ADDR_W-1:0]    access_address,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sctc_pkg::CLK_W-1:0]     cpu_clocks,
	output logic [sctc_pkg::OCNT_W-1:0]    timer0_count,
	output logic [sctc_pkg::OCNT_W-1:0]    timer1_count,
	output logic [sctc_pkg::OCNT_W-1:0]    timer2_count
);
	import sctc_pkg::*;

	// config registers
	speed_t            ext_speed_q;
	speed_t            int_speed_q;
	logic              boot_rom_q;
	logic              running_q;
	logic [NUM_TIMERS-1:0] en_mask_q;
	logic [CMP_W-1:0]  target0_q;
	logic [CMP_W-1:0]  target1_q;
	logic [CMP_W-1:0]  target2_q;

	// pipeline
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              out_valid_q;
	logic [CLK_W-1:0]  cpu_clocks_q;

	logic              advance;
	logic [CLK_W-1:0]  cost;
	logic [TICK_W-1:0] ticks;
	timer_ctrl_t       tctrl;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_speed_q <= '0;
			int_speed_q <= '0;
			boot_rom_q  <= 1'b1;
			running_q   <= 1'b1;
			en_mask_q   <= '0;
			target0_q   <= '0;
			target1_q   <= '0;
			target2_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXT_SPEED: ext_speed_q <= cfg_data[1:0];
				REG_INT_SPEED: int_speed_q <= cfg_data[1:0];
				REG_BOOT_ROM:  boot_rom_q  <= cfg_data[0];
				REG_RUNNING:   running_q   <= cfg_data[0];
				REG_EN_MASK:   en_mask_q   <= cfg_data[NUM_TIMERS-1:0];
				REG_TARGET0:   target0_q   <= cfg_data;
				REG_TARGET1:   target1_q   <= cfg_data;
				REG_TARGET2:   target2_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: s1 moves on when the result slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			addr_s1 <= access_address;
		end
	end

	// Address decode
	sctc_wait_sel u_wait_sel (
		.addr             (addr_s1),
		.ext_speed        (ext_speed_q),
		.int_speed        (int_speed_q),
		.boot_rom_enabled (boot_rom_q),
		.cost             (cost),
		.ticks            (ticks)
	);

	assign tctrl.adv     = advance;
	assign tctrl.ticks   = ticks;
	assign tctrl.running = running_q;

	// Timers; state doubles as the result counters
	sctc_timer u_timer0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tctrl),
		.fast   (1'b0),
		.enable (en_mask_q[0]),
		.target (target0_q),
		.count  (timer0_count)
	);

	sctc_timer u_timer1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tctrl),
		.fast   (1'b0),
		.enable (en_mask_q[1]),
		.target (target1_q),
		.count  (timer1_count)
	);

	sctc_timer u_timer2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tctrl),
		.fast   (1'b1),
		.enable (en_mask_q[2]),
		.target (target2_q),
		.count  (timer2_count)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cpu_clocks_q <= cost;
		end
	end

	assign out_valid  = out_valid_q;
	assign cpu_clocks = cpu_clocks_q;

	// Checks
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result slot empty after advance");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

	a_cost_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cpu_clocks_q == COST_TABLE[0] || cpu_clocks_q == COST_TABLE[1] ||
			cpu_clocks_q == COST_TABLE[2] || cpu_clocks_q == COST_TABLE[3]))
		else $error("illegal cpu clock cost");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(timer0_count) && $stable(timer1_count) &&
			$stable(timer2_count)))
		else $error("timer counter moved without an access");

endmodule

// ===== tb/sctc_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// sctc_scoreboard_pkg
// Access-cost and timer-count predictor with an in-order result checker.
// It follows the register writes and requests seen at the ports and holds the
// expected results until the block hands them out.
// ----------------------------------------------------------------------------
package sctc_scoreboard_pkg;

	import sctc_pkg::*;

	// Wait factor per speed index; the cost is 12 master clocks per factor unit
	localparam int unsigned WAIT_FACTOR [4] = '{2, 4, 10, 20};
	// Prescaler ticks added per access, per speed index
	localparam int unsigned TICK_STEP [4] = '{2, 4, 8, 16};
	localparam int unsigned CLOCKS_PER_UNIT = 12;

	typedef struct packed {
		logic [CLK_W-1:0]  cpu_clocks;
		logic [OCNT_W-1:0] timer0_count;
		logic [OCNT_W-1:0] timer1_count;
		logic [OCNT_W-1:0] timer2_count;
	} access_result_t;

	class access_scoreboard;

		// register copy
		speed_t                ext_speed;
		speed_t                int_speed;
		logic                  boot_rom_on;
		logic                  timers_on;
		logic [NUM_TIMERS-1:0] compare_enable;
		logic [CMP_W-1:0]      target [NUM_TIMERS];

		// timer chain copy
		logic [PRE_W-1:0]      prescale [NUM_TIMERS];
		logic                  toggle [NUM_TIMERS];
		logic                  prev_line [NUM_TIMERS];
		logic [CMP_W-1:0]      compare_cnt [NUM_TIMERS];
		logic [OCNT_W-1:0]     output_cnt [NUM_TIMERS];

		access_result_t        expected_q [$];
		int unsigned           failures;

		function new();
			ext_speed      = '0;
			int_speed      = '0;
			boot_rom_on    = 1'b1;
			timers_on      = 1'b1;
			compare_enable = '0;
			failures       = 0;
			for (int t = 0; t < NUM_TIMERS; t++) begin
				target[t]      = '0;
				prescale[t]    = '0;
				toggle[t]      = 1'b0;
				prev_line[t]   = 1'b0;
				compare_cnt[t] = '0;
				output_cnt[t]  = '0;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Register write seen at the port; unmapped indexes and high bits are dropped
		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_EXT_SPEED: ext_speed = data[1:0];
				REG_INT_SPEED: int_speed = data[1:0];
				REG_BOOT_ROM:  boot_rom_on = data[0];
				REG_RUNNING:   timers_on = data[0];
				REG_EN_MASK:   compare_enable = data[NUM_TIMERS-1:0];
				REG_TARGET0:   target[0] = data;
				REG_TARGET1:   target[1] = data;
				REG_TARGET2:   target[2] = data;
				default: ;
			endcase
		endfunction

		// One timer: prescaler, toggle, gated falling edge, compare, output count
		function void advance_timer(int unsigned t, int unsigned ticks);
			int unsigned length;
			logic        line;
			logic        falling;
			length = (t == NUM_TIMERS - 1) ? FAST_PRESCALE : SLOW_PRESCALE;
			prescale[t] = prescale[t] + PRE_W'(ticks);
			if (prescale[t] < length)
				return;
			prescale[t] = prescale[t] - PRE_W'(length);
			toggle[t] = ~toggle[t];
			// closed gate forces the line low, so a high line still falls
			line = timers_on & toggle[t];
			falling = prev_line[t] & ~line;
			prev_line[t] = line;
			if (!falling || !compare_enable[t])
				return;
			compare_cnt[t] = compare_cnt[t] + 1'b1;
			// target zero only matches after the count wraps through 256
			if (compare_cnt[t] != target[t])
				return;
			compare_cnt[t] = '0;
			output_cnt[t] = output_cnt[t] + 1'b1;
		endfunction

		// Accepted request: decode the speed, step the timers, queue the result
		function void note_access(logic [ADDR_W-1:0] addr);
			speed_t         sel;
			access_result_t want;
			sel = ext_speed;
			if ((addr & IO_PAGE_MASK) == IO_PAGE_BASE)
				sel = int_speed;
			else if (boot_rom_on && addr >= BOOT_ROM_BASE)
				sel = int_speed;
			for (int t = 0; t < NUM_TIMERS; t++)
				advance_timer(t, TICK_STEP[sel]);
			want.cpu_clocks   = CLK_W'(CLOCKS_PER_UNIT * WAIT_FACTOR[sel]);
			want.timer0_count = output_cnt[0];
			want.timer1_count = output_cnt[1];
			want.timer2_count = output_cnt[2];
			expected_q.push_back(want);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(access_result_t got);
			access_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request pending: cpu_clocks %0d", got.cpu_clocks);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("cpu_clocks", want.cpu_clocks, got.cpu_clocks);
			compare_field("timer0_count", want.timer0_count, got.timer0_count);
			compare_field("timer1_count", want.timer1_count, got.timer1_count);
			compare_field("timer2_count", want.timer2_count, got.timer2_count);
		endfunction

	endclass

endpackage

// ===== tb/tb_sound_cpu_wait_and_timer_chain.sv =====
// ----------------------------------------------------------------------------
// tb_sound_cpu_wait_and_timer_chain
// Checks access cost decode and the three timer chains against a predictor.
// Directed decode boundaries first, then phases of random addresses under
// varied register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sound_cpu_wait_and_timer_chain;

	timeunit 1ns;
	timeprecision 1ps;

	import sctc_pkg::*;
	import sctc_scoreboard_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned NUM_PHASES  = 12;
	localparam int unsigned HOLD_PHASE  = 4;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned WRAP_ITEMS  = 560;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_TARGET2 + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

	typedef enum logic [1:0] {
		PHASE_MIN,
		PHASE_MAX,
		PHASE_WRAP,
		PHASE_RANDOM
	} phase_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [ADDR_W-1:0]    access_address;
	logic                 out_valid;
	logic                 out_stall;
	logic [CLK_W-1:0]     cpu_clocks;
	logic [OCNT_W-1:0]    timer0_count;
	logic [OCNT_W-1:0]    timer1_count;
	logic [OCNT_W-1:0]    timer2_count;

	access_scoreboard     sb;
	bit                   no_gaps;
	bit                   hold_receiver;
	int unsigned          idle_cycles = 0;

	sound_cpu_wait_and_timer_chain i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.access_address (access_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cpu_clocks     (cpu_clocks),
		.timer0_count   (timer0_count),
		.timer1_count   (timer1_count),
		.timer2_count   (timer2_count)
	);

	always #5ns clk = ~clk;

	// Port monitor: register writes, results and requests in handshake order
	always @(posedge clk) begin : monitor
		access_result_t seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				seen.cpu_clocks   = cpu_clocks;
				seen.timer0_count = timer0_count;
				seen.timer1_count = timer1_count;
				seen.timer2_count = timer2_count;
				sb.check_result(seen);
			end
			if (in_valid && !in_stall)
				sb.note_access(access_address);
		end
	end

	// Watchdog: cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("sound_cpu_wait_and_timer_chain test failed");
				$finish;
			end
		end
	end

	// Result side: random stall per result, one long hold-off on request
	initial begin : result_sink
		int unsigned hold;
		out_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_receiver) begin
				hold = HOLD_CYCLES;
				hold_receiver = 1'b0;
			end else begin
				hold = no_gaps ? 0 : $urandom_range(0, 3);
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Writes every register; bits above each register's width carry noise
	task automatic set_registers(input speed_t ext_sel, input speed_t int_sel, input logic boot,
			input logic run, input logic [NUM_TIMERS-1:0] mask, input logic [CMP_W-1:0] t0,
			input logic [CMP_W-1:0] t1, input logic [CMP_W-1:0] t2);
		write_register(REG_EXT_SPEED, {6'($urandom_range(0, 63)), ext_sel});
		write_register(REG_INT_SPEED, {6'($urandom_range(0, 63)), int_sel});
		write_register(REG_BOOT_ROM, {7'($urandom_range(0, 127)), boot});
		write_register(REG_RUNNING, {7'($urandom_range(0, 127)), run});
		write_register(REG_EN_MASK, {5'($urandom_range(0, 31)), mask});
		write_register(REG_TARGET0, t0);
		write_register(REG_TARGET1, t1);
		write_register(REG_TARGET2, t2);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_access(input logic [ADDR_W-1:0] addr);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		access_address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Sender pause until every expected result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Mostly decode-relevant regions, the rest anywhere in the address space
	function automatic logic [ADDR_W-1:0] random_address();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return IO_PAGE_BASE | ADDR_W'($urandom_range(0, 15));
		if (pick < 5)
			return BOOT_ROM_BASE | ADDR_W'($urandom_range(0, 63));
		if (pick < 6)
			return ADDR_W'($urandom_range(IO_PAGE_BASE - 16, IO_PAGE_BASE + 31));
		return ADDR_W'($urandom());
	endfunction

	// Small targets keep the output counters moving
	function automatic logic [CMP_W-1:0] random_target();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return CMP_W'($urandom_range(1, 4));
		if (pick == 6)
			return '0;
		if (pick == 7)
			return '1;
		return CMP_W'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		logic [ADDR_W-1:0] decode_points [$];
		phase_kind_t       kind;
		int unsigned       count;

		sb             = new();
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		access_address = '0;
		no_gaps        = 1'b0;
		hold_receiver  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decode boundaries, internal speed differs from external speed
		set_registers(2'd0, 2'd3, 1'b1, 1'b1, 3'b111, 8'd1, 8'd2, 8'd1);
		decode_points = '{16'h0000, 16'hFFFF, 16'h00EF, 16'h00F0, 16'h00FF, 16'h0100,
			16'h10F0, 16'hFFBF, 16'hFFC0, 16'hFFEF, 16'hFFF0, 16'h7FFF};
		foreach (decode_points[i])
			send_access(decode_points[i]);
		wait_for_results();

		// Boot ROM unmapped: top of memory falls back to external speed
		set_registers(2'd1, 2'd3, 1'b0, 1'b1, 3'b101, 8'd0, 8'd1, 8'd3);
		send_access(16'hFFC0);
		send_access(16'hFFFF);
		send_access(16'h00F3);
		wait_for_results();

		// Unmapped register indexes must not disturb anything
		write_register(REG_UNUSED_FIRST, '1);
		write_register(REG_UNUSED_LAST, '1);
		cfg_valid <= 1'b0;
		send_access(16'h0000);
		send_access(16'h00F0);
		wait_for_results();

		// Close the gate while timer 2's line is high: still a falling edge
		set_registers(2'd3, 2'd3, 1'b1, 1'b1, 3'b111, 8'd1, 8'd1, 8'd1);
		send_access(16'h1234);
		wait_for_results();
		if (!sb.prev_line[NUM_TIMERS-1]) begin
			send_access(16'h4321);
			wait_for_results();
		end
		set_registers(2'd3, 2'd3, 1'b1, 1'b0, 3'b111, 8'd1, 8'd1, 8'd1);
		send_access(16'h8000);
		send_access(16'h00FA);

		// Random phases, each under its own register setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_for_results();
			if (p == 0)
				kind = PHASE_MIN;
			else if (p == 1)
				kind = PHASE_MAX;
			else if (p == 2)
				kind = PHASE_WRAP;
			else
				kind = PHASE_RANDOM;
			case (kind)
				PHASE_MIN: begin
					set_registers(2'd0, 2'd0, 1'b0, 1'b0, '0, '0, '0, '0);
				end
				PHASE_MAX: begin
					set_registers(2'd3, 2'd3, 1'b1, 1'b1, '1, '1, '1, '1);
				end
				PHASE_WRAP: begin
					// every access at top speed so timer 2's compare wraps through 256
					set_registers(2'd3, 2'd3, 1'($urandom_range(0, 1)), 1'b1, '1, '0, '0, '0);
				end
				default: begin
					set_registers(speed_t'($urandom_range(0, 3)), speed_t'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), ($urandom_range(0, 4) != 0),
						NUM_TIMERS'($urandom_range(0, 7)), random_target(), random_target(),
						random_target());
				end
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			if (p == HOLD_PHASE)
				hold_receiver = 1'b1;
			count = (kind == PHASE_WRAP) ? WRAP_ITEMS : PHASE_ITEMS;
			repeat (count)
				send_access(random_address());
		end

		wait_for_results();
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("sound_cpu_wait_and_timer_chain test passed");
		end else begin
			$display("sound_cpu_wait_and_timer_chain test failed");
		end
		$finish;
	end

endmodule
